>>> hw/rtl/reb_pkg.sv
// shared types and constants for the rotary encoder button qualifier
package reb_pkg;

  // event kind as carried on the input tuser
  typedef enum logic {
    KIND_BUTTON  = 1'b0,
    KIND_ENCODER = 1'b1
  } kind_t;

  // press report on a qualified release
  typedef enum logic [1:0] {
    PRESS_NONE  = 2'd0,
    PRESS_SHORT = 2'd1,
    PRESS_LONG  = 2'd2
  } press_t;

  // configuration register indexes
  localparam int REG_IDX_W = 2;
  typedef enum logic [REG_IDX_W-1:0] {
    REG_BUTTON_DEBOUNCE = 2'd0,
    REG_LONG_PRESS      = 2'd1,
    REG_ENCODER_LOCKOUT = 2'd2,
    REG_REVERSE_LOCKOUT = 2'd3
  } reg_index_t;

  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;
  localparam int POS_W  = 16;

  // register reset values
  localparam logic [CFG_W-1:0] BUTTON_DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST      = 16'd500;
  localparam logic [CFG_W-1:0] ENCODER_LOCKOUT_RST = 16'd250;
  localparam logic [CFG_W-1:0] REVERSE_LOCKOUT_RST = 16'd400;

  // classified event between front and back
  typedef struct packed {
    kind_t             kind;
    logic [TIME_W-1:0] now_ms;
    logic              dt_level;
  } item_t;

  // one result beat
  typedef struct packed {
    logic              button_held;
    press_t            press_event;
    logic              position_changed;
    logic signed [POS_W-1:0] position;
  } result_t;

endpackage

>>> hw/rtl/reb_front.sv
// input stage: takes stream beats, classifies them and hands them to the queue
module reb_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [39:0]                s_tdata,
  input  logic [0:0]                 s_tuser,
  output logic                       push_valid,
  input  logic                       push_ready,
  output reb_pkg::item_t             push_item
);

  logic           held_valid;
  reb_pkg::item_t item;

  // register frees up when empty or when the queue takes it
  assign s_tready   = !held_valid || push_ready;
  assign push_valid = held_valid;
  assign push_item  = item;

  // valid flag of the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tready) begin
      held_valid <= s_tvalid;
    end
  end

  // classify and capture the beat
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.kind     <= s_tuser[0] ? reb_pkg::KIND_ENCODER : reb_pkg::KIND_BUTTON;
      item.now_ms   <= s_tdata[reb_pkg::TIME_W-1:0];
      item.dt_level <= s_tdata[reb_pkg::TIME_W];
    end
  end

endmodule

>>> hw/rtl/reb_fifo.sv
// short queue of classified events between front and back
module reb_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  reb_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output reb_pkg::item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  reb_pkg::item_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // fill count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  // fill count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == $past(count) || count == $past(count) + 1'b1 ||
              count + 1'b1 == $past(count)))
    else $error("queue count jumped");

endmodule

>>> hw/rtl/reb_back.sv
// event execution: timing state, config registers and the result register
module reb_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [reb_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [reb_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                pop_valid,
  output logic                                pop_ready,
  input  reb_pkg::item_t                      pop_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output reb_pkg::result_t                    out_result
);

  logic [reb_pkg::CFG_W-1:0]  button_debounce_ms;
  logic [reb_pkg::CFG_W-1:0]  long_press_ms;
  logic [reb_pkg::CFG_W-1:0]  encoder_lockout_ms;
  logic [reb_pkg::CFG_W-1:0]  reverse_lockout_ms;

  logic [reb_pkg::TIME_W-1:0] last_button_time;
  logic [reb_pkg::TIME_W-1:0] last_encoder_time;
  logic                       held;
  logic                       last_direction;
  logic [reb_pkg::POS_W-1:0]  step_count;

  logic [reb_pkg::TIME_W-1:0] button_gap;
  logic [reb_pkg::TIME_W-1:0] encoder_gap;
  logic                       button_ok;
  logic                       encoder_ok;
  logic                       take_button;
  logic                       take_encoder;
  logic                       pop;
  logic [reb_pkg::POS_W-1:0]  step_count_next;
  logic                       held_next;
  reb_pkg::press_t            press_next;

  assign cfg_ready = 1'b1;

  // result register takes a new beat when empty or being drained
  assign pop_ready = !out_valid || out_ready;
  assign pop       = pop_valid && pop_ready;

  // gap tests, modulo 2^32
  assign button_gap  = pop_item.now_ms - last_button_time;
  assign encoder_gap = pop_item.now_ms - last_encoder_time;
  assign button_ok   = button_gap >= {{(reb_pkg::TIME_W-reb_pkg::CFG_W){1'b0}},
                                      button_debounce_ms};
  assign encoder_ok  =
    (encoder_gap >= {{(reb_pkg::TIME_W-reb_pkg::CFG_W){1'b0}}, encoder_lockout_ms}) &&
    !((encoder_gap < {{(reb_pkg::TIME_W-reb_pkg::CFG_W){1'b0}}, reverse_lockout_ms}) &&
      (pop_item.dt_level != last_direction));

  assign take_button  = pop && (pop_item.kind == reb_pkg::KIND_BUTTON) && button_ok;
  assign take_encoder = pop && (pop_item.kind == reb_pkg::KIND_ENCODER) && encoder_ok;

  // next state and press report
  always_comb begin
    step_count_next = step_count;
    held_next       = held;
    press_next      = reb_pkg::PRESS_NONE;
    if (take_button) begin
      held_next = !held;
      if (held) begin
        press_next = (button_gap > {{(reb_pkg::TIME_W-reb_pkg::CFG_W){1'b0}},
                                    long_press_ms}) ?
                     reb_pkg::PRESS_LONG : reb_pkg::PRESS_SHORT;
      end
    end
    if (take_encoder) begin
      step_count_next = pop_item.dt_level ? step_count + 1'b1 : step_count - 1'b1;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      button_debounce_ms <= reb_pkg::BUTTON_DEBOUNCE_RST;
      long_press_ms      <= reb_pkg::LONG_PRESS_RST;
      encoder_lockout_ms <= reb_pkg::ENCODER_LOCKOUT_RST;
      reverse_lockout_ms <= reb_pkg::REVERSE_LOCKOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        reb_pkg::REG_BUTTON_DEBOUNCE: button_debounce_ms <= cfg_data;
        reb_pkg::REG_LONG_PRESS:      long_press_ms      <= cfg_data;
        reb_pkg::REG_ENCODER_LOCKOUT: encoder_lockout_ms <= cfg_data;
        reb_pkg::REG_REVERSE_LOCKOUT: reverse_lockout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // qualifier state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_button_time  <= '0;
      last_encoder_time <= '0;
      held              <= 1'b0;
      last_direction    <= 1'b0;
      step_count        <= '0;
    end else begin
      if (take_button) begin
        last_button_time <= pop_item.now_ms;
      end
      if (take_encoder) begin
        last_encoder_time <= pop_item.now_ms;
        last_direction    <= pop_item.dt_level;
      end
      held       <= held_next;
      step_count <= step_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_ready) begin
      out_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_result.position         <= step_count_next;
      out_result.position_changed <= take_encoder;
      out_result.press_event      <= press_next;
      out_result.button_held      <= held_next;
    end
  end

  // held state only moves on a button event
  a_held_source: assert property (@(posedge clk) disable iff (rst)
    !(pop && pop_item.kind == reb_pkg::KIND_BUTTON) |=> $stable(held))
    else $error("held state changed without a button event");

  // encoder events never report a press
  a_encoder_no_press: assert property (@(posedge clk) disable iff (rst)
    (pop && pop_item.kind == reb_pkg::KIND_ENCODER) |=>
      out_result.press_event == reb_pkg::PRESS_NONE)
    else $error("press reported on an encoder event");

  // a reported press is always a release
  a_press_released: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.press_event != reb_pkg::PRESS_NONE) |->
      (!out_result.button_held && !out_result.position_changed))
    else $error("press reported while held or with a step");

endmodule

>>> hw/rtl/rotary_encoder_button_qualifier_top.sv
// Rotary encoder and push button event qualifier, top level.
// Takes one edge event per beat and returns exactly one result beat per event, in
// order. A new event can be accepted every clock cycle unless output back-pressure
// has filled the queue; the rate is set by the back end, which tests the event
// against the timing state and updates it. When nothing stalls, an event passes the
// input register, one queue entry and the result register, in that order, before
// its result is valid on the output. The queue of QUEUE_DEPTH entries lets input
// and output stall independently. Configuration writes are always taken and should
// be made while no event is in flight.
module rotary_encoder_button_qualifier_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  // event input
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [39:0]                   s_tdata,   // now_ms[31:0], dt_level[32], zero pad
  input  logic [0:0]                    s_tuser,   // operation[0]
  // result output
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,   // position[15:0], position_changed[16],
                                                   // press_event[18:17], button_held[19], pad
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [reb_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [reb_pkg::CFG_W-1:0]     cfg_data
);

  logic             push_valid;
  logic             push_ready;
  reb_pkg::item_t   push_item;
  logic             pop_valid;
  logic             pop_ready;
  reb_pkg::item_t   pop_item;
  reb_pkg::result_t out_result;

  reb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  reb_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  reb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (out_result)
  );

  // pack the result beat
  assign m_tdata = {4'b0000, out_result};

endmodule

>>> sim/tb_rotary_encoder_button_qualifier_top.sv
// testbench for the rotary encoder button qualifier, checked beat by beat against a predictor
module tb_rotary_encoder_button_qualifier_top;

  localparam int IDLE_LIMIT   = 5000;
  localparam int PHASES       = 6;
  localparam int PHASE_EVENTS = 310;
  localparam int REPORT_MAX   = 10;

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [39:0]                   s_tdata;   // now_ms[31:0], dt_level[32], zero pad
  logic [0:0]                    s_tuser;   // operation[0]
  logic                          m_tvalid;
  logic                          m_tready;
  logic [23:0]                   m_tdata;   // position[15:0], position_changed[16],
                                            // press_event[18:17], button_held[19], pad
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [reb_pkg::REG_IDX_W-1:0] cfg_index;
  logic [reb_pkg::CFG_W-1:0]     cfg_data;

  rotary_encoder_button_qualifier_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // one row of the directed table
  typedef struct {
    reb_pkg::kind_t   kind;
    logic [31:0]      now;
    logic             dt;
    bit               known;
    reb_pkg::result_t want;
  } edge_row_t;

  // predictor copy of the timing registers and state
  logic [reb_pkg::CFG_W-1:0]        debounce_ms;
  logic [reb_pkg::CFG_W-1:0]        long_hold_ms;
  logic [reb_pkg::CFG_W-1:0]        lockout_ms;
  logic [reb_pkg::CFG_W-1:0]        reverse_ms;
  logic [31:0]                      btn_last_ms;
  logic [31:0]                      enc_last_ms;
  logic                             btn_held;
  logic                             enc_last_dir;
  logic signed [reb_pkg::POS_W-1:0] enc_pos;

  reb_pkg::result_t pending_results[$];
  edge_row_t        edge_rows[$];
  int               fault_count;
  int               idle_cycles;
  int               tx_calm;
  logic [31:0]      clock_ms;
  logic             turn_dir;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // qualify one edge event and return the result beat it should cause
  function automatic reb_pkg::result_t qualify_event(reb_pkg::kind_t kind, logic [31:0] now,
                                                     logic dt);
    reb_pkg::result_t r;
    logic [31:0]      gap;
    r = '0;
    r.press_event = reb_pkg::PRESS_NONE;
    if (kind == reb_pkg::KIND_BUTTON) begin
      gap = now - btn_last_ms;
      if (gap >= {16'd0, debounce_ms}) begin
        if (btn_held)
          r.press_event = (gap > {16'd0, long_hold_ms}) ? reb_pkg::PRESS_LONG :
                                                         reb_pkg::PRESS_SHORT;
        btn_last_ms = now;
        btn_held    = ~btn_held;
      end
    end else begin
      gap = now - enc_last_ms;
      // lockout first, then the reverse lockout on a change of direction
      if (gap >= {16'd0, lockout_ms} &&
          !(gap < {16'd0, reverse_ms} && dt != enc_last_dir)) begin
        enc_last_ms  = now;
        enc_pos      = dt ? enc_pos + 16'sd1 : enc_pos - 16'sd1;
        enc_last_dir = dt;
        r.position_changed = 1'b1;
      end
    end
    r.position    = enc_pos;
    r.button_held = btn_held;
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)      return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else             return $urandom_range(20, 40);
  endfunction

  function automatic string show(reb_pkg::result_t r);
    return $sformatf("pos=%0d chg=%0b press=%0d held=%0b",
                     r.position, r.position_changed, r.press_event, r.button_held);
  endfunction

  task automatic note_fault(string msg);
    fault_count++;
    if (fault_count <= REPORT_MAX)
      $display("mismatch: %s", msg);
  endtask

  // send one event beat; starts and ends at a falling edge
  task automatic send_event(reb_pkg::kind_t kind, logic [31:0] now, logic dt, bit known,
                            reb_pkg::result_t want);
    reb_pkg::result_t got;
    if (tx_calm > 0) begin
      tx_calm--;
    end else if ($urandom_range(0, 59) == 0) begin
      tx_calm = $urandom_range(30, 100);
    end else begin
      repeat (idle_len()) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {7'd0, dt, now};
    s_tuser  = kind;
    do @(posedge clk); while (!s_tready);
    got = qualify_event(kind, now, dt);
    pending_results.push_back(known ? want : got);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // write one register; starts and ends at a falling edge
  task automatic write_reg(reb_pkg::reg_index_t idx, logic [reb_pkg::CFG_W-1:0] value);
    repeat (idle_len()) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      reb_pkg::REG_BUTTON_DEBOUNCE: debounce_ms  = value;
      reb_pkg::REG_LONG_PRESS:      long_hold_ms = value;
      reb_pkg::REG_ENCODER_LOCKOUT: lockout_ms   = value;
      reb_pkg::REG_REVERSE_LOCKOUT: reverse_ms   = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // random edge, mostly a turning knob and plausible button timing
  task automatic random_event();
    reb_pkg::kind_t kind;
    logic [31:0]    now;
    logic [31:0]    span;
    logic [31:0]    thr;
    logic           dt;
    int             r;
    kind = reb_pkg::kind_t'($urandom_range(0, 1));
    if ($urandom_range(0, 15) == 0) turn_dir = ~turn_dir;
    dt   = ($urandom_range(0, 4) == 0) ? 1'($urandom_range(0, 1)) : turn_dir;
    span = 32'd4 + 2 * {16'd0, (kind == reb_pkg::KIND_BUTTON) ?
           ((debounce_ms > long_hold_ms) ? debounce_ms : long_hold_ms) :
           ((lockout_ms > reverse_ms) ? lockout_ms : reverse_ms)};
    r = $urandom_range(0, 99);
    if (r < 5) begin
      now = clock_ms;
    end else if (r < 70) begin
      clock_ms = clock_ms + $urandom_range(0, span);
      now = clock_ms;
    end else if (r < 90) begin
      // land on a threshold, one below, on it or one above
      if (kind == reb_pkg::KIND_BUTTON) begin
        thr = {16'd0, $urandom_range(0, 1) ? debounce_ms : long_hold_ms};
        now = btn_last_ms + thr + $urandom_range(0, 2) - 32'd1;
      end else begin
        thr = {16'd0, $urandom_range(0, 1) ? lockout_ms : reverse_ms};
        now = enc_last_ms + thr + $urandom_range(0, 2) - 32'd1;
      end
      clock_ms = now;
    end else if (r < 97) begin
      clock_ms = clock_ms + $urandom;
      now = clock_ms;
    end else begin
      now = $urandom;
    end
    send_event(kind, now, dt, 1'b0, '0);
  endtask

  task automatic add_row(reb_pkg::kind_t kind, logic [31:0] now, logic dt, bit known,
                         logic signed [15:0] pos, logic chg, reb_pkg::press_t press,
                         logic held);
    edge_row_t row;
    row.kind = kind;
    row.now  = now;
    row.dt   = dt;
    row.known = known;
    row.want.position         = pos;
    row.want.position_changed = chg;
    row.want.press_event      = press;
    row.want.button_held      = held;
    edge_rows.push_back(row);
  endtask

  // result checker
  always @(posedge clk) begin
    reb_pkg::result_t got;
    reb_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = reb_pkg::result_t'(m_tdata[19:0]);
      if (pending_results.size() == 0) begin
        note_fault($sformatf("unexpected result beat: %s", show(got)));
      end else begin
        want = pending_results.pop_front();
        if (got.position !== want.position ||
            got.position_changed !== want.position_changed ||
            got.press_event !== want.press_event ||
            got.button_held !== want.button_held)
          note_fault($sformatf("expected %s, got %s", show(want), show(got)));
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left  = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (calm_left > 0) begin
        calm_left--;
        m_tready = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready = 1'b0;
      end else begin
        if ($urandom_range(0, 49) == 0)
          calm_left = $urandom_range(40, 150);
        else
          stall_left = idle_len();
        m_tready = (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // stimulus
  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    fault_count  = 0;
    idle_cycles  = 0;
    tx_calm      = 0;
    turn_dir     = 1'b1;
    debounce_ms  = reb_pkg::BUTTON_DEBOUNCE_RST;
    long_hold_ms = reb_pkg::LONG_PRESS_RST;
    lockout_ms   = reb_pkg::ENCODER_LOCKOUT_RST;
    reverse_ms   = reb_pkg::REVERSE_LOCKOUT_RST;
    btn_last_ms  = '0;
    enc_last_ms  = '0;
    btn_held     = 1'b0;
    enc_last_dir = 1'b0;
    enc_pos      = '0;

    // directed edges under reset settings
    add_row(reb_pkg::KIND_BUTTON,  32'd10,   1'b0, 1, 16'sd0,  1'b0,
            reb_pkg::PRESS_NONE,  1'b0);
    add_row(reb_pkg::KIND_ENCODER, 32'd100,  1'b1, 1, 16'sd0,  1'b0,
            reb_pkg::PRESS_NONE,  1'b0);
    add_row(reb_pkg::KIND_BUTTON,  32'd49,   1'b0, 1, 16'sd0,  1'b0,
            reb_pkg::PRESS_NONE,  1'b0);
    add_row(reb_pkg::KIND_BUTTON,  32'd50,   1'b0, 1, 16'sd0,  1'b0,
            reb_pkg::PRESS_NONE,  1'b1);
    add_row(reb_pkg::KIND_BUTTON,  32'd99,   1'b0, 1, 16'sd0,  1'b0,
            reb_pkg::PRESS_NONE,  1'b1);
    add_row(reb_pkg::KIND_BUTTON,  32'd600,  1'b0, 1, 16'sd0,  1'b0,
            reb_pkg::PRESS_LONG,  1'b0);
    add_row(reb_pkg::KIND_BUTTON,  32'd650,  1'b1, 0, 16'sd0,  1'b0,
            reb_pkg::PRESS_NONE,  1'b0);
    add_row(reb_pkg::KIND_BUTTON,  32'd1150, 1'b0, 1, 16'sd0,  1'b0,
            reb_pkg::PRESS_SHORT, 1'b0);
    add_row(reb_pkg::KIND_ENCODER, 32'd250,  1'b0, 1, -16'sd1, 1'b1,
            reb_pkg::PRESS_NONE,  1'b0);
    add_row(reb_pkg::KIND_ENCODER, 32'd500,  1'b1, 0, 16'sd0,  1'b0,
            reb_pkg::PRESS_NONE,  1'b0);
    add_row(reb_pkg::KIND_ENCODER, 32'd650,  1'b1, 0, 16'sd0,  1'b0,
            reb_pkg::PRESS_NONE,  1'b0);
    add_row(reb_pkg::KIND_ENCODER, 32'd899,  1'b1, 0, 16'sd0,  1'b0,
            reb_pkg::PRESS_NONE,  1'b0);
    add_row(reb_pkg::KIND_ENCODER, 32'd900,  1'b1, 0, 16'sd0,  1'b0,
            reb_pkg::PRESS_NONE,  1'b0);
    add_row(reb_pkg::KIND_ENCODER, 32'hFFFF_FF00, 1'b0, 0, 16'sd0, 1'b0,
            reb_pkg::PRESS_NONE, 1'b0);
    add_row(reb_pkg::KIND_ENCODER, 32'h0000_0010, 1'b0, 0, 16'sd0, 1'b0,
            reb_pkg::PRESS_NONE, 1'b0);
    add_row(reb_pkg::KIND_BUTTON,  32'hFFFF_FFFF, 1'b0, 0, 16'sd0, 1'b0,
            reb_pkg::PRESS_NONE, 1'b0);
    add_row(reb_pkg::KIND_BUTTON,  32'h0000_0100, 1'b1, 0, 16'sd0, 1'b0,
            reb_pkg::PRESS_NONE, 1'b0);
    add_row(reb_pkg::KIND_ENCODER, 32'hFFFF_FFFF, 1'b1, 0, 16'sd0, 1'b0,
            reb_pkg::PRESS_NONE, 1'b0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (edge_rows[i])
      send_event(edge_rows[i].kind, edge_rows[i].now, edge_rows[i].dt,
                 edge_rows[i].known, edge_rows[i].want);

    // random phases, each under its own register settings
    clock_ms = $urandom;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain_results();
        case (phase)
          1: begin
            write_reg(reb_pkg::REG_BUTTON_DEBOUNCE, 16'd0);
            write_reg(reb_pkg::REG_LONG_PRESS,      16'd0);
            write_reg(reb_pkg::REG_ENCODER_LOCKOUT, 16'd0);
            write_reg(reb_pkg::REG_REVERSE_LOCKOUT, 16'd0);
          end
          2: begin
            write_reg(reb_pkg::REG_BUTTON_DEBOUNCE, 16'hFFFF);
            write_reg(reb_pkg::REG_LONG_PRESS,      16'hFFFF);
            write_reg(reb_pkg::REG_ENCODER_LOCKOUT, 16'hFFFF);
            write_reg(reb_pkg::REG_REVERSE_LOCKOUT, 16'hFFFF);
          end
          3: begin
            write_reg(reb_pkg::REG_BUTTON_DEBOUNCE, 16'd1);
            write_reg(reb_pkg::REG_LONG_PRESS,      16'd2);
            write_reg(reb_pkg::REG_ENCODER_LOCKOUT, 16'd3);
            write_reg(reb_pkg::REG_REVERSE_LOCKOUT, 16'd5);
          end
          4: begin
            // reverse lockout shorter than the plain lockout
            write_reg(reb_pkg::REG_BUTTON_DEBOUNCE, 16'd20);
            write_reg(reb_pkg::REG_LONG_PRESS,      16'd1000);
            write_reg(reb_pkg::REG_ENCODER_LOCKOUT, 16'd300);
            write_reg(reb_pkg::REG_REVERSE_LOCKOUT, 16'd100);
          end
          default: begin
            write_reg(reb_pkg::REG_REVERSE_LOCKOUT, 16'($urandom_range(0, 65535)));
            write_reg(reb_pkg::REG_LONG_PRESS,      16'($urandom_range(0, 2000)));
            write_reg(reb_pkg::REG_BUTTON_DEBOUNCE, 16'($urandom_range(0, 200)));
            write_reg(reb_pkg::REG_ENCODER_LOCKOUT, 16'($urandom_range(0, 65535)));
          end
        endcase
      end
      for (int n = 0; n < PHASE_EVENTS; n++) begin
        // halfway through each phase the sender holds off until the output side has caught up
        if (n == PHASE_EVENTS / 2)
          while (pending_results.size() != 0) @(negedge clk);
        random_event();
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (fault_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> rotary_encoder_button_qualifier_top.f
hw/rtl/reb_pkg.sv
hw/rtl/reb_front.sv
hw/rtl/reb_fifo.sv
hw/rtl/reb_back.sv
hw/rtl/rotary_encoder_button_qualifier_top.sv
sim/tb_rotary_encoder_button_qualifier_top.sv
